// ----- hw/rtl/itoad_pkg.sv -----
// Package for the integer to ASCII digit converter: word types and character codes.
// Has no dependencies; used by integer_to_ascii_digits_top.
package itoad_pkg;

  // Fixed widths of the input value, of the result character and of one digit.
  localparam int unsigned IN_VALUE_W = 64;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned NIBBLE_W   = 4;

  // Radix select codes.
  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  // Digit values used by the converter.
  localparam logic [NIBBLE_W-1:0] DEC_RADIX  = 4'd10;
  localparam logic [NIBBLE_W-1:0] DABBLE_MIN = 4'd5;
  localparam logic [NIBBLE_W-1:0] DABBLE_ADD = 4'd3;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic                  mode;
    logic                  is_signed;
    logic                  upper_case;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  // ASCII character for one digit value.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIBBLE_W-1:0] d,
                                                   input logic hex,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CHAR_UPPER : CHAR_LOWER;
    if (hex && (d >= DEC_RADIX)) begin
      digit_char = base + {4'b0000, d} - {4'b0000, DEC_RADIX};
    end else begin
      digit_char = CHAR_ZERO + {4'b0000, d};
    end
  endfunction

endpackage

// ----- hw/rtl/integer_to_ascii_digits_top.sv -----
// Integer to ASCII digit converter, top level: bit-serial binary to BCD or hex conversion
// followed by one character per cycle. Depends on itoad_pkg.
//
//   channel  ports                        handshake
//   input    start, busy, in_word         word taken when start is high and busy is low
//   output   out_valid, out_word          one word per cycle of out_valid, never stalled
//
// A number passes through the conversion loop, which shifts one value bit into the digit
// register per cycle, then through a step that deals with the sign, then through a sweep
// of the digit register. For a negative number the sweep covers one digit slot fewer, as
// its minus sign goes out in place of the top digit. Digit characters appear during the
// sweep; leading zero digits are skipped and give no word. Reset is synchronous and
// active low and returns the block to idle. The receiver cannot hold results off, so
// busy depends only on the block's own work.
module integer_to_ascii_digits_top #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned DIGIT_SLOTS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  itoad_pkg::in_t   in_word,
  output logic             out_valid,
  output itoad_pkg::out_t  out_word
);

  localparam int unsigned DIG_W      = DIGIT_SLOTS * itoad_pkg::NIBBLE_W;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned SLOT_CNT_W = $clog2(DIGIT_SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_LEAD,
    S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]  work_r, work_nxt;
  logic [DIG_W-1:0]        dig_r, dig_nxt;
  logic [BIT_CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [SLOT_CNT_W-1:0]   slot_cnt_r, slot_cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    started_r, started_nxt;
  logic                    hex_r, hex_nxt;
  logic                    upper_r, upper_nxt;
  logic                    neg_r, neg_nxt;
  logic                    busy_r, busy_nxt;
  logic                    out_valid_r, out_valid_nxt;
  itoad_pkg::out_t         out_word_r, out_word_nxt;

  logic [VALUE_WIDTH-1:0]  in_value;
  logic                    in_neg;
  logic [DIG_W-1:0]        dig_adj;
  logic [itoad_pkg::NIBBLE_W-1:0] top_digit;
  logic                    skip;

  assign in_value  = in_word.value[VALUE_WIDTH-1:0];
  assign in_neg    = (in_word.mode == itoad_pkg::MODE_DEC) && in_word.is_signed &&
                     in_value[VALUE_WIDTH-1];
  assign top_digit = dig_r[DIG_W-1 -: itoad_pkg::NIBBLE_W];
  // A leading zero is dropped unless a non-zero digit has already been seen or
  // it is the final digit position.
  assign skip      = !started_r && (top_digit == '0) && (slot_cnt_r != SLOT_CNT_W'(1));

  // Double-dabble correction: in decimal mode every digit of five or more gets three
  // added before the shift, so that the shift carries it correctly into the next digit.
  always_comb begin
    dig_adj = dig_r;
    if (hex_r == itoad_pkg::MODE_DEC) begin
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
        if (dig_r[i*itoad_pkg::NIBBLE_W +: itoad_pkg::NIBBLE_W] >= itoad_pkg::DABBLE_MIN) begin
          dig_adj[i*itoad_pkg::NIBBLE_W +: itoad_pkg::NIBBLE_W] =
            dig_r[i*itoad_pkg::NIBBLE_W +: itoad_pkg::NIBBLE_W] + itoad_pkg::DABBLE_ADD;
        end
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    dig_nxt       = dig_r;
    bit_cnt_nxt   = bit_cnt_r;
    slot_cnt_nxt  = slot_cnt_r;
    ovf_nxt       = ovf_r;
    started_nxt   = started_r;
    hex_nxt       = hex_r;
    upper_nxt     = upper_r;
    neg_nxt       = neg_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // The magnitude of a negative number is formed once, here.
          work_nxt    = in_neg ? ({VALUE_WIDTH{1'b0}} - in_value) : in_value;
          hex_nxt     = in_word.mode;
          upper_nxt   = in_word.upper_case;
          neg_nxt     = in_neg;
          dig_nxt     = '0;
          ovf_nxt     = 1'b0;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_WIDTH);
          busy_nxt    = 1'b1;
          state_nxt   = S_CONV;
        end
      end

      S_CONV: begin
        // One value bit enters the digit register per cycle, most significant first.
        // A one leaving the top digit means the number has more digits than slots.
        dig_nxt     = {dig_adj[DIG_W-2:0], work_r[VALUE_WIDTH-1]};
        ovf_nxt     = ovf_r | dig_adj[DIG_W-1];
        work_nxt    = {work_r[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(1)) begin
          state_nxt = S_LEAD;
        end
      end

      S_LEAD: begin
        if (neg_r) begin
          // The minus sign takes the top slot, so the top digit is discarded.
          out_valid_nxt          = 1'b1;
          out_word_nxt.character = itoad_pkg::CHAR_MINUS;
          out_word_nxt.last      = 1'b0;
          started_nxt            = ovf_r | (top_digit != '0);
          dig_nxt                = {dig_r[DIG_W-itoad_pkg::NIBBLE_W-1:0],
                                    {itoad_pkg::NIBBLE_W{1'b0}}};
          slot_cnt_nxt           = SLOT_CNT_W'(DIGIT_SLOTS - 1);
        end else begin
          started_nxt  = ovf_r;
          slot_cnt_nxt = SLOT_CNT_W'(DIGIT_SLOTS);
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        dig_nxt      = {dig_r[DIG_W-itoad_pkg::NIBBLE_W-1:0], {itoad_pkg::NIBBLE_W{1'b0}}};
        slot_cnt_nxt = slot_cnt_r - SLOT_CNT_W'(1);
        if (!skip) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.character = itoad_pkg::digit_char(top_digit, hex_r, upper_r);
          out_word_nxt.last      = (slot_cnt_r == SLOT_CNT_W'(1));
          started_nxt            = 1'b1;
        end
        if (slot_cnt_r == SLOT_CNT_W'(1)) begin
          busy_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        busy_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    work_r     <= work_nxt;
    dig_r      <= dig_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    slot_cnt_r <= slot_cnt_nxt;
    ovf_r      <= ovf_nxt;
    started_r  <= started_nxt;
    hex_r      <= hex_nxt;
    upper_r    <= upper_nxt;
    neg_r      <= neg_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
